// ===== hw/rtl/dpr_pkg.sv =====
// shared types, character codes and hex helpers for the debug packet receiver
package dpr_pkg;

  typedef enum logic [2:0] {
    MODE_IDLE = 3'd0,
    MODE_LINE = 3'd1,
    MODE_ESC  = 3'd2,
    MODE_RUN  = 3'd3,
    MODE_CK1  = 3'd4,
    MODE_CK2  = 3'd5
  } rx_mode_e;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_ACK  = 2'd1,
    KIND_NAK  = 2'd2,
    KIND_DROP = 2'd3
  } kind_e;

  localparam logic [7:0] CharStart  = 8'h24; // '$'
  localparam logic [7:0] CharEscape = 8'h7d; // '}'
  localparam logic [7:0] CharRun    = 8'h2a; // '*'
  localparam logic [7:0] CharHash   = 8'h23; // '#'
  localparam logic [7:0] CharSpace  = 8'h20; // ' '
  localparam logic [7:0] EscapeXor  = 8'h20;
  localparam logic [7:0] RunOffset  = 8'd29; // count minus space plus three

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  data_byte;
    logic [7:0]  repeat_count;
    logic [11:0] packet_len;
  } result_t;

  function automatic logic hex_ok(input logic [7:0] c);
    hex_ok = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
             (c >= 8'h61 && c <= 8'h66);
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] v;
    v = 8'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = c - 8'h30;
    end else if (c >= 8'h41 && c <= 8'h46) begin
      v = c - 8'h37;
    end else if (c >= 8'h61 && c <= 8'h66) begin
      v = c - 8'h57;
    end
    hex_val = v[3:0];
  endfunction

endpackage

// ===== hw/rtl/dpr_decode.sv =====
// per-byte decode: next receiver state and the optional result word
module dpr_decode #(
  parameter int BUFFER_BYTES = 4096,
  parameter int CW = $clog2(BUFFER_BYTES)
) (
  input  logic [7:0]       rx_byte_i,
  input  dpr_pkg::rx_mode_e mode_i,
  input  logic [CW-1:0]    count_i,
  input  logic [7:0]       sum_i,
  input  logic [3:0]       nib_i,
  input  logic [7:0]       last_i,
  output dpr_pkg::rx_mode_e mode_o,
  output logic [CW-1:0]    count_o,
  output logic [7:0]       sum_o,
  output logic [3:0]       nib_o,
  output logic [7:0]       last_o,
  output logic             res_valid_o,
  output dpr_pkg::result_t res_o
);
  import dpr_pkg::*;

  // run sum is wide enough for the count plus a full 8-bit run length
  localparam int RW = ((CW > 8) ? CW : 8) + 1;

  localparam logic [CW-1:0] Limit  = CW'(BUFFER_BYTES - 1);
  localparam logic [RW-1:0] LimitW = RW'(BUFFER_BYTES - 1);

  logic [7:0]    rep;
  logic [RW-1:0] run_total;
  logic          full;

  assign rep       = rx_byte_i - RunOffset;
  assign run_total = RW'(count_i) + RW'(rep);
  assign full      = (count_i >= Limit);

  always_comb begin
    mode_o      = mode_i;
    count_o     = count_i;
    sum_o       = sum_i;
    nib_o       = nib_i;
    last_o      = last_i;
    res_valid_o = 1'b0;
    res_o.kind         = KIND_DATA;
    res_o.data_byte    = 8'd0;
    res_o.repeat_count = 8'd0;
    case (mode_i)
      MODE_LINE, MODE_ESC: begin
        if (mode_i == MODE_LINE && rx_byte_i == CharEscape) begin
          sum_o  = sum_i + rx_byte_i;
          mode_o = MODE_ESC;
        end else if (mode_i == MODE_LINE && rx_byte_i == CharRun) begin
          sum_o  = sum_i + rx_byte_i;
          mode_o = MODE_RUN;
        end else if (rx_byte_i == CharHash) begin
          mode_o = MODE_CK1;
        end else if (full) begin
          mode_o      = MODE_IDLE;
          res_valid_o = 1'b1;
          res_o.kind  = KIND_DROP;
        end else begin
          count_o     = count_i + CW'(1);
          sum_o       = sum_i + rx_byte_i;
          last_o      = (mode_i == MODE_ESC) ? (rx_byte_i ^ EscapeXor) : rx_byte_i;
          mode_o      = MODE_LINE;
          res_valid_o = 1'b1;
          res_o.data_byte    = last_o;
          res_o.repeat_count = 8'd1;
        end
      end
      MODE_RUN: begin
        if (rx_byte_i < CharSpace) begin
          mode_o = MODE_LINE;
        end else if (run_total >= LimitW) begin
          mode_o      = MODE_IDLE;
          res_valid_o = 1'b1;
          res_o.kind  = KIND_DROP;
        end else if (count_i == '0) begin
          // run with nothing to repeat
          mode_o = MODE_LINE;
        end else begin
          count_o     = run_total[CW-1:0];
          sum_o       = sum_i + rx_byte_i;
          mode_o      = MODE_LINE;
          res_valid_o = 1'b1;
          res_o.data_byte    = last_i;
          res_o.repeat_count = rep;
        end
      end
      MODE_CK1: begin
        if (!hex_ok(rx_byte_i)) begin
          mode_o = MODE_LINE;
        end else begin
          nib_o  = hex_val(rx_byte_i);
          mode_o = MODE_CK2;
        end
      end
      MODE_CK2: begin
        if (!hex_ok(rx_byte_i)) begin
          mode_o = MODE_LINE;
        end else begin
          mode_o      = MODE_IDLE;
          res_valid_o = 1'b1;
          res_o.kind  = ({nib_i, hex_val(rx_byte_i)} == sum_i) ? KIND_ACK : KIND_NAK;
        end
      end
      default: begin
        mode_o = MODE_IDLE;
        if (rx_byte_i == CharStart) begin
          count_o = '0;
          sum_o   = 8'd0;
          mode_o  = MODE_LINE;
        end
      end
    endcase
    res_o.packet_len = 12'(count_o);
  end

endmodule

// ===== hw/rtl/dpr_out_buf.sv =====
// output register with one skid entry behind it
module dpr_out_buf (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  dpr_pkg::result_t push_data_i,
  output logic             full_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output dpr_pkg::result_t out_data_o
);
  import dpr_pkg::*;

  logic    out_valid_d, out_valid_q;
  logic    skid_valid_d, skid_valid_q;
  result_t out_data_d, out_data_q;
  result_t skid_data_d, skid_data_q;
  logic    out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_data_d   = out_data_q;
    skid_data_d  = skid_data_q;
    if (out_free) begin
      if (skid_valid_q) begin
        out_valid_d  = 1'b1;
        out_data_d   = skid_data_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = push_i;
        if (push_i) begin
          out_data_d = push_data_i;
        end
      end
    end else if (push_i) begin
      skid_valid_d = 1'b1;
      skid_data_d  = push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    skid_data_q <= skid_data_d;
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== hw/rtl/debug_packet_receiver_core.sv =====
// top level of the debug packet receiver: state registers, decode and output buffer
//
// Takes one received byte per word on the input channel and decodes the debugger
// remote-protocol framing: '$' opens a packet, '}' escapes the next byte (xor 0x20),
// '*' plus a count byte repeats the last byte, '#' plus two hex digits closes the
// packet with an ack or nak word. Each byte is decoded in the cycle it is accepted,
// so one word can enter every clock: the decode is a single pass of logic between the
// receiver state registers and the result register. Results sit in an output register
// with one skid entry behind it; input stall rises only when both hold a word, so a
// stalled output still lets bytes in until one more result word lands in the skid
// entry. A word yields at most one result word, which reaches the output register the
// cycle after the word is accepted unless an earlier result is still waiting there.
// BUFFER_BYTES sets the payload limit: a plain or escaped byte arriving once
// BUFFER_BYTES-1 bytes are collected, or a run that would bring the count to
// BUFFER_BYTES-1 or beyond, is reported as dropped.
module debug_packet_receiver_core #(
  parameter int BUFFER_BYTES = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  data_byte_o,
  output logic [7:0]  repeat_count_o,
  output logic [11:0] packet_len_o
);
  import dpr_pkg::*;

  localparam int CW = $clog2(BUFFER_BYTES);

  // receiver state
  rx_mode_e      mode_d, mode_q;
  logic [CW-1:0] count_d, count_q;
  logic [7:0]    sum_d, sum_q;
  logic [3:0]    nib_d, nib_q;
  logic [7:0]    last_d, last_q;

  logic    in_accept;
  logic    res_valid;
  result_t res;
  logic    buf_full;
  result_t out_data;

  // stall only depends on the skid register
  assign in_stall_o = buf_full;
  assign in_accept  = in_valid_i && !buf_full;

  dpr_decode #(
    .BUFFER_BYTES(BUFFER_BYTES),
    .CW(CW)
  ) u_decode (
    .rx_byte_i  (rx_byte_i),
    .mode_i     (mode_q),
    .count_i    (count_q),
    .sum_i      (sum_q),
    .nib_i      (nib_q),
    .last_i     (last_q),
    .mode_o     (mode_d),
    .count_o    (count_d),
    .sum_o      (sum_d),
    .nib_o      (nib_d),
    .last_o     (last_d),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  // state advances only on an accepted word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      count_q <= '0;
      sum_q   <= 8'd0;
      nib_q   <= 4'd0;
      last_q  <= 8'd0;
    end else if (in_accept) begin
      mode_q  <= mode_d;
      count_q <= count_d;
      sum_q   <= sum_d;
      nib_q   <= nib_d;
      last_q  <= last_d;
    end
  end

  dpr_out_buf u_out_buf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (in_accept && res_valid),
    .push_data_i(res),
    .full_o     (buf_full),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data)
  );

  assign kind_o         = out_data.kind;
  assign data_byte_o    = out_data.data_byte;
  assign repeat_count_o = out_data.repeat_count;
  assign packet_len_o   = out_data.packet_len;

`ifndef NO_ASSERTIONS
  // skid entry is only filled behind a waiting output word
  assert property (@(posedge clk_i) disable iff (!rst_ni) buf_full |-> out_valid_o)
    else $error("skid entry holds a word while output register is empty");

  // payload count never passes the buffer limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(BUFFER_BYTES - 1))
    else $error("byte count beyond buffer limit");

  // bytes outside a packet never produce a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && mode_q == MODE_IDLE) |-> !res_valid)
    else $error("result produced outside a packet");

  // after an accepted word with a result, the output holds a valid word next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && res_valid) |=> out_valid_o)
    else $error("result word lost");
`endif

endmodule
